FILE: design/bfb_pkg.sv
package bfb_pkg;

    localparam int STORE_BYTES_DEF = 32;
    localparam int CFG_W           = 6;
    localparam int BYTE_IDX_W      = 5;
    localparam int PADDR_W         = 3;

    localparam logic [CFG_W-1:0] BYTES_IN_USE_RST = 6'd32;
    localparam logic [4:0]       MAX_FIELD_BITS   = 5'd16;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_BYTES_IN_USE = 1'b0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  field_lsb;
        logic [4:0]  field_width;
        logic [15:0] write_value;
    } t_in_req;

    typedef struct packed {
        logic [15:0] read_value;
        logic        range_error;
    } t_out_req;

    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic                  clr;
        logic [BYTE_IDX_W-1:0] addr;
        logic [7:0]            wdata;
    } t_mem_cmd;

    typedef struct packed {
        logic [2:0]  shift;
        logic [4:0]  width;
        logic [15:0] wval;
        logic [1:0]  k;
    } t_fld_ctl;

endpackage

FILE: design/bit_field_buffer_top.sv
// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_ready      i_in_req  (operation, offset, width, value)
// out      output     o_out_valid / i_out_ready    o_out_req (read_value, range_error)
// cfg      input      psel, penable, pwrite        paddr, pwdata, prdata; pready tied high
//
// Read/write: after accept, a read step and a modify step per byte spanned (1 to 3), then done;
// each byte is one read then one write/capture on the single-port byte memory.
// Clear, rejected field and unused code go from accept straight to done. Clear empties all valid bits at once.
// Synchronous active-low reset empties the store and sets bytes_in_use to 32.
// A result waits in the output register; the next request runs while it is held.
module bit_field_buffer_top #(
    parameter int STORE_BYTES = bfb_pkg::STORE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bfb_pkg::t_in_req              i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bfb_pkg::t_out_req             o_out_req,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bfb_pkg::*;

    localparam logic [CFG_W-1:0] STORE_BYTES_C = CFG_W'(STORE_BYTES);

    logic [CFG_W-1:0] r_bytes;
    logic             r_out_vld;
    t_out_req         r_out;

    logic [CFG_W-1:0] usable;
    logic             cfg_wr;
    t_mem_cmd         mem_cmd;
    logic [7:0]       rdata;
    t_fld_ctl         fld_ctl;
    logic [7:0]       new_byte;
    logic [7:0]       ext;
    logic             done;
    logic             take;
    t_out_req         res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BYTES_IN_USE);
    assign prdata = (paddr[2] == REG_BYTES_IN_USE) ? {26'h0, r_bytes} : 32'h0;
    assign usable = (r_bytes > STORE_BYTES_C) ? STORE_BYTES_C : r_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= BYTES_IN_USE_RST;
        end else if (cfg_wr) begin
            r_bytes <= pwdata[CFG_W-1:0];
        end
    end

    assign take = done && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    bfb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .i_usable    (usable),
        .o_mem       (mem_cmd),
        .o_fld       (fld_ctl),
        .i_new_byte  (new_byte),
        .i_ext       (ext),
        .o_done      (done),
        .i_done_take (take),
        .o_res       (res)
    );

    bfb_field u_field (
        .i_ctl (fld_ctl),
        .i_old (rdata),
        .o_new (new_byte),
        .o_ext (ext)
    );

    bfb_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mem_cmd),
        .o_rdata (rdata)
    );

endmodule

FILE: design/bfb_store.sv
module bfb_store #(
    parameter int STORE_BYTES = bfb_pkg::STORE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfb_pkg::t_mem_cmd i_cmd,
    output logic [7:0]        o_rdata
);
    import bfb_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [7:0]             r_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_vld;
    logic [7:0]             r_rdata;
    logic                   r_rvld;
    logic [AW-1:0]          addr;

    assign addr = i_cmd.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= i_cmd.wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    // entries not written since reset or clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_vld <= '0;
            end else if (i_cmd.wr_en) begin
                r_vld[addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rvld <= r_vld[addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 8'h00;

endmodule

FILE: design/bfb_field.sv
module bfb_field (
    input  bfb_pkg::t_fld_ctl i_ctl,
    input  logic [7:0]        i_old,
    output logic [7:0]        o_new,
    output logic [7:0]        o_ext
);
    import bfb_pkg::*;

    logic [16:0] mask17;
    logic [31:0] mask32;
    logic [31:0] data32;
    logic [7:0]  m;
    logic [7:0]  d;

    always_comb begin
        mask17 = (17'd1 << i_ctl.width) - 17'd1;
        mask32 = {16'h0000, mask17[15:0]} << i_ctl.shift;
        data32 = {16'h0000, i_ctl.wval & mask17[15:0]} << i_ctl.shift;
        m      = mask32[{i_ctl.k, 3'b000} +: 8];
        d      = data32[{i_ctl.k, 3'b000} +: 8];
        o_new  = (i_old & ~m) | d;
        o_ext  = i_old & m;
    end

endmodule

FILE: design/bfb_seq.sv
module bfb_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bfb_pkg::t_in_req           i_in_req,
    input  logic [bfb_pkg::CFG_W-1:0]  i_usable,
    output bfb_pkg::t_mem_cmd          o_mem,
    output bfb_pkg::t_fld_ctl          o_fld,
    input  logic [7:0]                 i_new_byte,
    input  logic [7:0]                 i_ext,
    output logic                       o_done,
    input  logic                       i_done_take,
    output bfb_pkg::t_out_req          o_res
);
    import bfb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MOD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                r_state;
    logic [1:0]            r_op;
    logic [7:0]            r_lsb;
    logic [4:0]            r_w;
    logic [15:0]           r_wval;
    logic                  r_err;
    logic [1:0]            r_k;
    logic [1:0]            r_last;
    logic [BYTE_IDX_W-1:0] r_addr;
    logic [23:0]           r_acc;

    logic       accept;
    logic       rw_op;
    logic [8:0] msb;
    logic       bad;
    logic [1:0] span;

    assign accept = i_in_valid && o_in_ready;
    assign rw_op  = (i_in_req.operation == OP_READ) || (i_in_req.operation == OP_WRITE);
    assign msb    = {1'b0, i_in_req.field_lsb} + {4'h0, i_in_req.field_width} - 9'd1;
    assign bad    = (i_in_req.field_width == 5'd0) || (i_in_req.field_width > MAX_FIELD_BITS)
                    || msb[8] || ({1'b0, msb[7:3]} >= i_usable);
    assign span   = 2'(msb[7:3] - i_in_req.field_lsb[7:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_err <= rw_op && bad;
                        if (rw_op && !bad) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_k == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (i_done_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_op   <= i_in_req.operation;
            r_lsb  <= i_in_req.field_lsb;
            r_w    <= i_in_req.field_width;
            r_wval <= i_in_req.write_value;
            r_k    <= 2'd0;
            r_last <= span;
            r_addr <= i_in_req.field_lsb[7:3];
            r_acc  <= '0;
        end else if (r_state == S_MOD) begin
            if (r_op == OP_READ) begin
                r_acc <= r_acc | ({16'h0000, i_ext} << {r_k, 3'b000});
            end
            r_k    <= 2'(r_k + 2'd1);
            r_addr <= BYTE_IDX_W'(r_addr + 1'b1);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_mem.rd_en = (r_state == S_READ);
        o_mem.wr_en = (r_state == S_MOD) && (r_op == OP_WRITE);
        o_mem.clr   = accept && (i_in_req.operation == OP_CLEAR);
        o_mem.addr  = r_addr;
        o_mem.wdata = i_new_byte;
    end

    always_comb begin
        o_fld.shift = r_lsb[2:0];
        o_fld.width = r_w;
        o_fld.wval  = r_wval;
        o_fld.k     = r_k;
    end

    assign o_done            = (r_state == S_DONE);
    assign o_res.read_value  = (r_op == OP_READ) ? 16'(r_acc >> r_lsb[2:0]) : 16'h0000;
    assign o_res.range_error = r_err;

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_MOD) |-> (r_k <= r_last) && (r_last <= 2'd2))
        else $error("byte step beyond field span");

    a_bad_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && rw_op && bad) |=> (r_state == S_DONE) && r_err)
        else $error("rejected field touched the store");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_req.operation == OP_CLEAR) |=> (r_state == S_DONE) && !r_err)
        else $error("clear did not finish at once");

    a_mod_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |=> (r_state == S_READ) || (r_state == S_DONE))
        else $error("bad step after modify");

endmodule

FILE: test/bfb_checker.sv
`timescale 1ns / 100ps

module bfb_checker
    import bfb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_req            i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_req           i_out_req,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_fail_count,
    output int                 o_checked,
    output int                 o_outstanding
);

    localparam logic [PADDR_W-1:0] BYTES_IN_USE_ADDR = PADDR_W'(4 * REG_BYTES_IN_USE);
    localparam int unsigned        LAST_BIT          = 255;

    logic [7:0]       shadow_bytes [STORE_BYTES];
    logic [CFG_W-1:0] bytes_cfg;
    t_out_req         expected_results [$];
    int               fail_count = 0;
    int               checked    = 0;

    // Applies one request to the shadow store and returns the result it should produce.
    function automatic t_out_req apply_field_op(t_in_req r);
        t_out_req    res;
        int unsigned usable;
        int unsigned msb;
        int unsigned pos;
        bit          ok;
        res    = '0;
        usable = (bytes_cfg > STORE_BYTES) ? STORE_BYTES : bytes_cfg;
        msb    = r.field_lsb + r.field_width - 1;
        ok     = (r.field_width != 0) && (r.field_width <= MAX_FIELD_BITS) &&
                 (msb <= LAST_BIT) && ((msb >> 3) < usable);
        case (r.operation)
            OP_CLEAR: begin
                for (int b = 0; b < STORE_BYTES; b++) shadow_bytes[b] = '0;
            end
            OP_READ, OP_WRITE: begin
                if (!ok) begin
                    res.range_error = 1'b1;
                end else begin
                    for (int i = 0; i < r.field_width; i++) begin
                        pos = r.field_lsb + i;
                        if (r.operation == OP_READ)
                            res.read_value[i] = shadow_bytes[pos >> 3][pos & 7];
                        else
                            shadow_bytes[pos >> 3][pos & 7] = r.write_value[i];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_req want;
        if (!i_rst_n) begin
            for (int b = 0; b < STORE_BYTES; b++) shadow_bytes[b] = '0;
            bytes_cfg = BYTES_IN_USE_RST;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: read_value %h range_error %b",
                           i_out_req.read_value, i_out_req.range_error);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.read_value !== i_out_req.read_value) begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, i_out_req.read_value);
                        fail_count++;
                    end
                    if (want.range_error !== i_out_req.range_error) begin
                        $error("range_error: expected %b, got %b",
                               want.range_error, i_out_req.range_error);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_field_op(i_in_req));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BYTES_IN_USE_ADDR)
                bytes_cfg = i_pwdata[CFG_W-1:0];
        end
        o_fail_count  <= fail_count;
        o_checked     <= checked;
        o_outstanding <= expected_results.size();
    end

endmodule

FILE: test/bit_field_buffer_top_test.sv
`timescale 1ns / 100ps

module bit_field_buffer_top_test;
    import bfb_pkg::*;

    localparam logic [1:0]         OP_UNUSED         = 2'd3;
    localparam logic [PADDR_W-1:0] BYTES_IN_USE_ADDR = PADDR_W'(4 * REG_BYTES_IN_USE);
    localparam int                 NUM_PHASES        = 10;
    localparam int                 PHASE_ITEMS       = 135;
    localparam int                 HOLD_CYCLES       = 300;
    localparam int                 HOLD_PHASE        = 4;
    localparam int                 NO_IDLE_PHASE     = 6;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_req            i_in_req;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_req           o_out_req;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int checked;
    int outstanding;
    int sent_count     = 0;
    int cfg_fail_count = 0;
    bit no_idle        = 1'b0;
    bit hold_pending   = 1'b0;

    logic [CFG_W-1:0] phase_cfg [NUM_PHASES] =
        '{6'd0, 6'd1, 6'd2, 6'd9, 6'd32, 6'd31, 6'd63, 6'd33, 6'd16, 6'd32};

    bit_field_buffer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bfb_checker field_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_req      (i_in_req),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_req     (o_out_req),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_checked     (checked),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_in_req make_req(logic [1:0] op, logic [7:0] offset,
                                         logic [4:0] width, logic [15:0] value);
        t_in_req r;
        r.operation   = op;
        r.field_lsb   = offset;
        r.field_width = width;
        r.write_value = value;
        return r;
    endfunction

    // Mostly in-range fields so the store actually fills; some bad widths and wild offsets.
    function automatic t_in_req random_req(int unsigned usable);
        t_in_req     r;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        r.operation = (pick < 46) ? OP_READ  :
                      (pick < 92) ? OP_WRITE :
                      (pick < 97) ? OP_CLEAR : OP_UNUSED;
        if ($urandom_range(0, 9) == 0) begin
            r.field_width = 5'($urandom_range(16, 31));
            if (r.field_width == 5'd16) r.field_width = '0;
        end else begin
            r.field_width = 5'($urandom_range(1, 16));
        end
        span = usable * 8;
        pick = $urandom_range(0, 9);
        if (pick < 8 && r.field_width != 0 && r.field_width <= 16 && span >= r.field_width)
            r.field_lsb = (pick == 0) ? 8'(span - r.field_width)
                                      : 8'($urandom_range(0, span - r.field_width));
        else
            r.field_lsb = 8'($urandom);
        r.write_value = 16'($urandom);
        return r;
    endfunction

    task automatic send_req(input t_in_req r);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 19) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (checked != sent_count) @(posedge i_clk);
    endtask

    task automatic write_bytes_in_use(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BYTES_IN_USE_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (prdata !== 32'(value)) begin
            $error("bytes_in_use: expected %0d, got %0d", value, prdata);
            cfg_fail_count++;
        end
    endtask

    // Receiver: random back-pressure plus one long hold-off to back up the pipe.
    initial begin
        int unsigned held;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 19);
        end
    end

    initial begin
        int unsigned usable;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(make_req(OP_READ,    8'd0,   5'd1,  16'h0000));
        send_req(make_req(OP_WRITE,   8'd0,   5'd16, 16'hFFFF));
        send_req(make_req(OP_READ,    8'd0,   5'd16, 16'h0000));
        send_req(make_req(OP_WRITE,   8'd3,   5'd16, 16'hA5C3));
        send_req(make_req(OP_READ,    8'd3,   5'd16, 16'h0000));
        send_req(make_req(OP_READ,    8'd0,   5'd8,  16'h0000));
        send_req(make_req(OP_WRITE,   8'd248, 5'd8,  16'hFF5A));
        send_req(make_req(OP_READ,    8'd255, 5'd1,  16'h0000));
        send_req(make_req(OP_READ,    8'd248, 5'd8,  16'h0000));
        send_req(make_req(OP_WRITE,   8'd241, 5'd16, 16'h1234));
        send_req(make_req(OP_READ,    8'd255, 5'd2,  16'h0000));
        send_req(make_req(OP_READ,    8'd10,  5'd0,  16'h0000));
        send_req(make_req(OP_WRITE,   8'd10,  5'd17, 16'hFFFF));
        send_req(make_req(OP_READ,    8'd200, 5'd31, 16'hFFFF));
        send_req(make_req(OP_UNUSED,  8'd77,  5'd9,  16'hBEEF));
        send_req(make_req(OP_READ,    8'd240, 5'd16, 16'h0000));
        send_req(make_req(OP_CLEAR,   8'hFF,  5'h1F, 16'hFFFF));
        send_req(make_req(OP_READ,    8'd0,   5'd16, 16'h0000));
        send_req(make_req(OP_WRITE,   8'd250, 5'd6,  16'hFFFF));
        send_req(make_req(OP_READ,    8'd250, 5'd6,  16'h0000));
        send_req(make_req(OP_READ,    8'd240, 5'd16, 16'h0000));
        send_req(make_req(OP_WRITE,   8'd128, 5'd16, 16'h8001));
        send_req(make_req(OP_READ,    8'd129, 5'd15, 16'h0000));
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_bytes_in_use(phase_cfg[p]);
            usable = (phase_cfg[p] > STORE_BYTES_DEF) ? STORE_BYTES_DEF : phase_cfg[p];
            no_idle = (p == NO_IDLE_PHASE);
            if (p == HOLD_PHASE) hold_pending = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_req(random_req(usable));
            drain();
            no_idle = 1'b0;
        end

        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests across %0d bytes_in_use settings, zero and oversized included",
                 sent_count, NUM_PHASES + 1);
        $display("Checked %0d results; one %0d-cycle receiver hold-off, one stretch without gaps",
                 checked, HOLD_CYCLES);
        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        if (fail_count == 0 && cfg_fail_count == 0 && outstanding == 0 &&
            checked == sent_count) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
